// ----- rtl/cfr_pkg.sv -----
`timescale 1ns / 1ps

package cfr_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_LEN = 6;

  // frame position codes
  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_CHECK = 3'd7;

  // accepted frame type codes
  localparam logic [7:0] TYPE_ONE = 8'd1;
  localparam logic [7:0] TYPE_TWO = 8'd2;

  // input beat: one received byte
  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  // output beat: one checked command frame
  typedef struct packed {
    logic [1:0] frame_code;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;
    logic [7:0] payload_5;
  } cmd_beat_t;

endpackage

// ----- rtl/cfr_stream_if.sv -----
`timescale 1ns / 1ps

// valid/ready channel carrying one payload per beat
interface cfr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/command_frame_receiver.sv -----
`timescale 1ns / 1ps

// channel   dir  payload      beat meaning
// rx_i      in   rx_beat_t    one received byte
// cmd_o     out  cmd_beat_t   one command frame with a good checksum
//
// One byte is taken every cycle while rx_i.ready is high; a byte waits in
// the input register, where the frame logic updates position, type, payload
// and running sum. A good checksum byte in the input register yields a frame
// beat in the output register, from which it is offered on cmd_o.
// Asynchronous active-low reset returns to hunting.
// While the output register holds an untaken beat, the frame logic and the
// input register stall; rx_i.ready drops only when the input register is full
// and its byte cannot move on.
module command_frame_receiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfr_stream_if.sink    rx_i,
  cfr_stream_if.source  cmd_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       step;

  logic [2:0] pos_q;
  logic [1:0] type_q;
  logic [7:0] sum_q;
  logic [7:0] sum_d;
  logic [2:0] wr_idx;
  logic [7:0] payload_q [cfr_pkg::PAYLOAD_LEN];
  logic       is_type;
  logic       match;

  logic                 out_valid_q;
  cfr_pkg::cmd_beat_t   out_q;

  // handshake and stall control
  assign out_free   = !out_valid_q || cmd_o.ready;
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  // frame decode on the registered byte
  assign is_type = (in_byte_q == cfr_pkg::TYPE_ONE) || (in_byte_q == cfr_pkg::TYPE_TWO);
  assign sum_d   = sum_q + in_byte_q;
  assign wr_idx  = pos_q - 3'd1;
  assign match   = (sum_q == in_byte_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
  end

  // frame position, type and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= cfr_pkg::POS_HUNT;
      type_q <= 2'd0;
      sum_q  <= 8'd0;
    end else if (step) begin
      case (pos_q)
        cfr_pkg::POS_HUNT: begin
          if (is_type) begin
            type_q <= in_byte_q[1:0];
            sum_q  <= in_byte_q;
            pos_q  <= 3'd1;
          end
        end
        cfr_pkg::POS_CHECK: begin
          pos_q <= cfr_pkg::POS_HUNT;
        end
        default: begin
          sum_q <= sum_d;
          pos_q <= pos_q + 3'd1;
        end
      endcase
    end
  end

  // payload store, one entry per payload position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cfr_pkg::PAYLOAD_LEN; i++) begin
      if (step && pos_q != cfr_pkg::POS_HUNT && pos_q != cfr_pkg::POS_CHECK
          && wr_idx == 3'(i)) begin
        payload_q[i] <= in_byte_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && pos_q == cfr_pkg::POS_CHECK && match) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && pos_q == cfr_pkg::POS_CHECK && match) begin
      out_q.frame_code <= type_q;
      out_q.payload_0  <= payload_q[0];
      out_q.payload_1  <= payload_q[1];
      out_q.payload_2  <= payload_q[2];
      out_q.payload_3  <= payload_q[3];
      out_q.payload_4  <= payload_q[4];
      out_q.payload_5  <= payload_q[5];
    end
  end

  assign cmd_o.valid   = out_valid_q;
  assign cmd_o.payload = out_q;

  // a new frame beat only follows a checksum byte
  a_beat_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(pos_q) == cfr_pkg::POS_CHECK))
    else $error("frame beat without checksum step");

  // a byte that is no type code keeps the receiver hunting
  a_hunt_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pos_q == cfr_pkg::POS_HUNT && !is_type) |=> (pos_q == cfr_pkg::POS_HUNT))
    else $error("left hunting on a bad type byte");

  // payload bytes advance the position by one
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pos_q != cfr_pkg::POS_HUNT && pos_q != cfr_pkg::POS_CHECK)
      |=> (pos_q == 3'($past(pos_q) + 3'd1)))
    else $error("position did not advance on a payload byte");

  // a delivered frame carries a legal type
  a_type_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.frame_code == 2'd1 || out_q.frame_code == 2'd2))
    else $error("illegal frame type in output beat");

endmodule
